// ----- rtl/core/qud_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qud_pkg
// Types shared by the queue union block: input and result words, FSM states.
// ----------------------------------------------------------------------------
package qud_pkg;

    localparam int unsigned KEY_W = 31;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             from_second;
        logic             end_of_union;
    } t_in_word;

    typedef struct packed {
        logic [KEY_W-1:0] out_key;
        logic             kept;
        logic             overflow;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST
    } t_state;

endpackage

// ----- rtl/core/qud_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qud_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module qud_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/queue_union_dedup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queue_union_dedup
// Merges two key queues without repeats. First-queue keys are passed on and
// stored while the RAM has room; second-queue keys that match one are dropped.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result appears on
// o_out with o_valid high for one cycle and cannot be held off. A first-queue
// key, or a second-queue key with the store empty, gives its result in the
// cycle after acceptance and busy stays low, so one word per cycle is taken.
// A second-queue key with n stored keys scans the key RAM one entry a cycle;
// busy is high through the scan and the final compare, the result shows in
// the cycle in which busy falls, and no new word is taken until then. The key
// RAM read port sets the pace of the scan.
module queue_union_dedup #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  qud_pkg::t_in_word i_in,
    output logic              o_valid,
    output qud_pkg::t_out_word o_out
);
    import qud_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    logic [KEY_W-1:0] r_key, n_key;
    logic             r_last, n_last;
    logic             r_hit, n_hit;
    logic             r_cmp_vld, n_cmp_vld;
    logic             r_valid, n_valid;
    t_out_word        r_out, n_out;

    logic             w_accept;
    logic             w_full;
    logic             w_we;
    logic [KEY_W-1:0] w_rdata;
    logic             w_match;

    assign w_accept = start && (r_state == S_IDLE);
    assign w_full   = (r_count == CAP_C);
    assign w_we     = w_accept && !i_in.from_second && !w_full;
    assign w_match  = (w_rdata == r_key);

    qud_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in.key),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_in.from_second && (r_count != '0)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == r_count - ONE_C) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_key     = r_key;
        n_last    = r_last;
        n_hit     = r_hit;
        n_cmp_vld = r_cmp_vld;
        n_valid   = 1'b0;
        n_out     = r_out;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_key     = i_in.key;
                    n_last    = i_in.end_of_union;
                    n_hit     = 1'b0;
                    n_cmp_vld = 1'b0;
                    n_idx     = '0;
                    if (!i_in.from_second || (r_count == '0)) begin
                        n_valid          = 1'b1;
                        n_out.out_key    = i_in.key;
                        n_out.kept       = 1'b1;
                        n_out.overflow   = !i_in.from_second && w_full;
                        if (i_in.end_of_union) begin
                            n_count = '0;
                        end else if (w_we) begin
                            n_count = r_count + ONE_C;
                        end
                    end
                end
            end
            S_SCAN: begin
                n_idx     = r_idx + ONE_C;
                n_cmp_vld = 1'b1;
                n_hit     = r_hit || (r_cmp_vld && w_match);
            end
            S_LAST: begin
                n_valid        = 1'b1;
                n_out.out_key  = r_key;
                n_out.kept     = !(r_hit || w_match);
                n_out.overflow = 1'b0;
                if (r_last) begin
                    n_count = '0;
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_idx     <= n_idx;
        r_key     <= n_key;
        r_last    <= n_last;
        r_hit     <= n_hit;
        r_cmp_vld <= n_cmp_vld;
        r_out     <= n_out;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_out   = r_out;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("key count beyond capacity");

    a_first_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_in.from_second) |=> (o_valid && o_out.kept))
        else $error("first-queue word gave no kept result");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAST) |=> (o_valid && !busy))
        else $error("scan end gave no result");

    a_ovf_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.overflow) |-> o_out.kept)
        else $error("overflow result not kept");
`endif

endmodule
